[src/threshold_peak_rate_meter_macros.svh]
// Assertion macros for the checker file tprm_checker.sv.
`ifndef THRESHOLD_PEAK_RATE_METER_MACROS_SVH
`define THRESHOLD_PEAK_RATE_METER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TPRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TPRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[src/tprm_pkg.sv]
// Package with the shared types and constants of the peak rate meter.
package tprm_pkg;
   localparam int CHANNELS = 16;
   localparam int CH_W = 4;
   localparam int GAP_W = 64;
   localparam int NUM_W = 22;
   localparam logic [31:0] RESET_THRESHOLD = 32'd3221225469;
   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_RATE = 1'b1;

   typedef struct packed {
      logic [3:0] channel_index;
      logic [31:0] sample_value;
      logic narrow_sample;
   } req_type;

   typedef struct packed {
      logic [3:0] result_channel;
      logic [21:0] beats_per_minute;
      logic zero_gap_error;
   } rsp_type;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic [GAP_W-1:0] gap;
   } job_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;
endpackage

[src/tprm_front.sv]
// Front end: per-channel peak tracking, one transaction per cycle while job_ready is high.
module tprm_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tprm_pkg::req_type req_data,
   input  logic [31:0] threshold,
   output logic job_valid,
   input  logic job_ready,
   output tprm_pkg::job_type job_data
);
   logic [63:0] counter_ff [tprm_pkg::CHANNELS];
   logic [63:0] counter_in;
   logic [tprm_pkg::CHANNELS-1:0] inpeak_ff, inpeak_in;
   logic [31:0] cur_h_ff [tprm_pkg::CHANNELS];
   logic [31:0] prev_h_ff [tprm_pkg::CHANNELS];
   logic [63:0] cur_p_ff [tprm_pkg::CHANNELS];
   logic [63:0] prev_p_ff [tprm_pkg::CHANNELS];
   logic [31:0] value;
   logic [3:0] ch;
   logic fire, above, higher, falling, emit;

   assign ch = req_data.channel_index;
   assign value = req_data.narrow_sample ?
      {req_data.sample_value[15:0], req_data.sample_value[15:0]} : req_data.sample_value;
   assign req_ready = job_ready;
   assign fire = req_valid && req_ready;
   assign above = value >= threshold;
   assign higher = value > cur_h_ff[ch];
   assign falling = !above && inpeak_ff[ch];
   assign emit = fire && falling && (prev_h_ff[ch] != 32'd0);
   assign counter_in = counter_ff[ch] + 64'd1;
   assign job_valid = emit;
   assign job_data.channel = ch;
   assign job_data.gap = cur_p_ff[ch] - prev_p_ff[ch];

   always_comb begin
      inpeak_in = inpeak_ff;
      inpeak_in[ch] = above;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inpeak_ff <= '0;
         for (int i = 0; i < tprm_pkg::CHANNELS; i++) begin
            counter_ff[i] <= '0;
            cur_h_ff[i] <= '0;
            prev_h_ff[i] <= '0;
            cur_p_ff[i] <= '0;
            prev_p_ff[i] <= '0;
         end
      end else if (fire) begin
         inpeak_ff <= inpeak_in;
         counter_ff[ch] <= counter_in;
         if (above) begin
            if (higher) begin
               cur_h_ff[ch] <= value;
               cur_p_ff[ch] <= counter_ff[ch];
            end
         end else if (inpeak_ff[ch]) begin
            prev_h_ff[ch] <= cur_h_ff[ch];
            prev_p_ff[ch] <= cur_p_ff[ch];
            cur_h_ff[ch] <= '0;
            cur_p_ff[ch] <= '0;
         end
      end
   end
endmodule

[src/tprm_queue.sv]
// Two-entry queue between front end and divider.
module tprm_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  tprm_pkg::job_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output tprm_pkg::job_type out_data
);
   tprm_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[src/tprm_back.sv]
// Back end: restoring divider computing the rate, with output register.
module tprm_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  tprm_pkg::job_type job_data,
   input  logic [15:0] rate_hz,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tprm_pkg::rsp_type rsp_data
);
   tprm_pkg::div_state_type state_ff, state_in;
   logic [21:0] quot_ff, quot_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] gap_ff;
   logic [4:0] step_ff, step_in;
   logic [3:0] chan_ff;
   logic err_ff;
   logic [64:0] trial;
   logic [21:0] numer;

   assign numer = {6'd0, rate_hz} * {16'd0, tprm_pkg::SECONDS_PER_MINUTE};
   assign trial = {rem_ff, quot_ff[21]} - {1'b0, gap_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tprm_pkg::DIV_IDLE: if (job_valid) state_in = tprm_pkg::DIV_RUN;
         tprm_pkg::DIV_RUN: if (step_ff == 5'd21) state_in = tprm_pkg::DIV_DONE;
         tprm_pkg::DIV_DONE: if (rsp_ready) state_in = tprm_pkg::DIV_IDLE;
         default: state_in = tprm_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      rsp_valid = 1'b0;
      quot_in = quot_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      unique case (state_ff)
         tprm_pkg::DIV_IDLE: begin
            job_ready = 1'b1;
            quot_in = numer;
            rem_in = '0;
            step_in = '0;
         end
         tprm_pkg::DIV_RUN: begin
            step_in = step_ff + 5'd1;
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quot_in = {quot_ff[20:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], quot_ff[21]};
               quot_in = {quot_ff[20:0], 1'b0};
            end
         end
         tprm_pkg::DIV_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_data.result_channel = chan_ff;
   assign rsp_data.beats_per_minute = err_ff ? 22'd0 : quot_ff;
   assign rsp_data.zero_gap_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tprm_pkg::DIV_IDLE;
      else state_ff <= state_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      if (state_ff == tprm_pkg::DIV_IDLE && job_valid) begin
         gap_ff <= job_data.gap;
         chan_ff <= job_data.channel;
         err_ff <= job_data.gap == 64'd0;
      end
   end
endmodule

[src/threshold_peak_rate_meter.sv]
// Top level of the threshold peak rate meter.
// Usage: samples arrive on the req_ channel as transactions tagged with a channel.
// The front end takes one transaction per cycle while the queue has room; each
// does one read-modify-write of that channel's counter and peak registers. When
// a peak ends and an earlier peak exists, a job is queued into a two-entry queue.
// The back end divides 60*sample_rate_hz by the peak gap with a restoring divider,
// one quotient bit per cycle, and holds the result on rsp_ until rsp_ready.
// Each job passes the queue and the divider's IDLE, RUN, DONE states to rsp_valid.
// Throughput is one sample per cycle while the queue has room; the divider takes
// a new job only after its last result has been taken.
// When rsp_ready is low the result waits; once the queue fills, req_ready drops.
// Reset is synchronous and clears all channel state and configuration to
// their reset values; csr_ writes update the registered threshold and rate.
module threshold_peak_rate_meter (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tprm_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tprm_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_wdata
);
   logic [31:0] thr_ff;
   logic [15:0] rate_ff;
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   tprm_pkg::job_type fq_data, qb_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tprm_pkg::RESET_THRESHOLD;
         rate_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tprm_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata;
            tprm_pkg::CSR_RATE: rate_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   tprm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .threshold(thr_ff), .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
   );

   tprm_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   tprm_back u_back (
      .clock, .reset, .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
      .rate_hz(rate_ff), .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

[src/tprm_checker.sv]
// Port-level checker for the peak rate meter, bound to the top level.
`include "threshold_peak_rate_meter_macros.svh"
module tprm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input tprm_pkg::rsp_type rsp_data
);
   `TPRM_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_data.zero_gap_error, rsp_data.beats_per_minute == 22'd0)
   `TPRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `TPRM_ASSERT_NEXT(a_one_per_take, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
endmodule

bind threshold_peak_rate_meter tprm_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data
);
